// ----- design/sftl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sftl_pkg
// Shared types and codes for the sorted table floor lookup block.
// ----------------------------------------------------------------------------
package sftl_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned IndexW  = 10;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_LOAD   = 2'd1,
    REQ_LOOKUP = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ST_FOUND      = 3'd0,
    ST_BELOW_BASE = 3'd1,
    ST_NO_COVER   = 3'd2,
    ST_ACCEPTED   = 3'd3,
    ST_DROPPED    = 3'd4,
    ST_CLEARED    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    REG_KERNEL_BASE = 2'd0,
    REG_ARENA_LOW   = 2'd1,
    REG_ARENA_HIGH  = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_PROBE,
    FSM_FETCH,
    FSM_RESP
  } fsm_e;

  typedef struct packed {
    logic [DataW-1:0] kernel_base;
    logic [DataW-1:0] arena_low;
    logic [DataW-1:0] arena_high;
  } cfg_t;

  typedef struct packed {
    logic             we;
    logic [DataW-1:0] addr;
    logic [DataW-1:0] name;
  } tbl_wr_t;

  typedef struct packed {
    status_e           status;
    logic [IndexW-1:0] entry_index;
    logic [DataW-1:0]  found_name;
    logic [DataW-1:0]  offset;
  } res_t;

endpackage

// ----- design/sftl_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sftl_table
// Entry storage: address and name memories, one write port, one registered
// read port shared by both.
// ----------------------------------------------------------------------------
module sftl_table #(
  parameter int unsigned TABLE_DEPTH = 1024,
  localparam int unsigned IdxW = $clog2(TABLE_DEPTH)
) (
  input  logic                   clk_i,
  input  sftl_pkg::tbl_wr_t      wr_i,
  input  logic [IdxW-1:0]        wr_idx_i,
  input  logic [IdxW-1:0]        rd_idx_i,
  output logic [sftl_pkg::DataW-1:0] rd_addr_o,
  output logic [sftl_pkg::DataW-1:0] rd_name_o
);
  import sftl_pkg::*;

  logic [DataW-1:0] addr_mem [TABLE_DEPTH];
  logic [DataW-1:0] name_mem [TABLE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      addr_mem[wr_idx_i] <= wr_i.addr;
      name_mem[wr_idx_i] <= wr_i.name;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_o <= addr_mem[rd_idx_i];
    rd_name_o <= name_mem[rd_idx_i];
  end

endmodule

// ----- design/sftl_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sftl_ctrl
// Request sequencer: entry count, load/clear handling and the binary search
// that probes the table one entry per cycle.
// ----------------------------------------------------------------------------
module sftl_ctrl #(
  parameter int unsigned TABLE_DEPTH = 1024,
  localparam int unsigned IdxW = $clog2(TABLE_DEPTH),
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sftl_pkg::cfg_t         cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             req_type_i,
  input  logic [sftl_pkg::DataW-1:0] addr_i,
  input  logic [sftl_pkg::DataW-1:0] name_ref_i,
  output sftl_pkg::tbl_wr_t      wr_o,
  output logic [IdxW-1:0]        wr_idx_o,
  output logic [IdxW-1:0]        rd_idx_o,
  input  logic [sftl_pkg::DataW-1:0] rd_addr_i,
  input  logic [sftl_pkg::DataW-1:0] rd_name_i,
  output logic                   res_valid_o,
  input  logic                   res_take_i,
  output sftl_pkg::res_t         res_o
);
  import sftl_pkg::*;

  localparam logic [CntW-1:0] Depth = CntW'(TABLE_DEPTH);
  localparam logic [CntW-1:0] One   = CntW'(1);

  fsm_e             state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  lo_q, lo_d;
  logic [CntW-1:0]  hi_q, hi_d;
  logic [CntW-1:0]  mid_q, mid_d;
  logic [DataW-1:0] query_q, query_d;
  res_t             res_q, res_d;

  logic [CntW-1:0]  lo_n, hi_n, mid_n, found_idx, fetch_idx;
  logic [31:0]      found_wide;

  assign found_idx  = lo_q - One;
  assign found_wide = 32'(found_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    query_q <= query_d;
    res_q   <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    query_d     = query_q;
    res_d       = res_q;
    wr_o        = '0;
    wr_idx_o    = cnt_q[IdxW-1:0];
    rd_idx_o    = mid_q[IdxW-1:0];
    in_stall_o  = (state_q != FSM_IDLE);
    res_valid_o = (state_q == FSM_RESP);
    lo_n        = lo_q;
    hi_n        = hi_q;
    mid_n       = mid_q;
    fetch_idx   = '0;

    case (state_q)
      FSM_IDLE: begin
        if (in_valid_i) begin
          res_d = '0;
          case (req_type_i)
            REQ_CLEAR: begin
              cnt_d        = '0;
              res_d.status = ST_CLEARED;
              state_d      = FSM_RESP;
            end
            REQ_LOAD: begin
              if (addr_i >= cfg_i.arena_low && addr_i < cfg_i.arena_high &&
                  cnt_q < Depth) begin
                wr_o.we      = 1'b1;
                wr_o.addr    = addr_i;
                wr_o.name    = name_ref_i;
                cnt_d        = cnt_q + One;
                res_d.status = ST_ACCEPTED;
              end else begin
                res_d.status = ST_DROPPED;
              end
              state_d = FSM_RESP;
            end
            REQ_LOOKUP: begin
              query_d = addr_i;
              if (addr_i < cfg_i.kernel_base) begin
                res_d.status = ST_BELOW_BASE;
                state_d      = FSM_RESP;
              end else if (cnt_q == '0) begin
                res_d.status = ST_NO_COVER;
                state_d      = FSM_RESP;
              end else begin
                lo_d     = '0;
                hi_d     = cnt_q;
                mid_d    = cnt_q >> 1;
                rd_idx_o = mid_d[IdxW-1:0];
                state_d  = FSM_PROBE;
              end
            end
            default: begin
              // unused request code: take the beat, give no result
            end
          endcase
        end
      end
      FSM_PROBE: begin
        // read data holds entry_addr[mid_q]; narrow the range and issue
        // the next probe in the same cycle
        if (rd_addr_i <= query_q) begin
          lo_n = mid_q + One;
        end else begin
          hi_n = mid_q;
        end
        mid_n = lo_n + ((hi_n - lo_n) >> 1);
        lo_d  = lo_n;
        hi_d  = hi_n;
        mid_d = mid_n;
        if (lo_n < hi_n) begin
          rd_idx_o = mid_n[IdxW-1:0];
        end else if (lo_n == '0) begin
          res_d        = '0;
          res_d.status = ST_NO_COVER;
          state_d      = FSM_RESP;
        end else begin
          fetch_idx = lo_n - One;
          rd_idx_o  = fetch_idx[IdxW-1:0];
          state_d   = FSM_FETCH;
        end
      end
      FSM_FETCH: begin
        res_d.status      = ST_FOUND;
        res_d.entry_index = found_wide[IndexW-1:0];
        res_d.found_name  = rd_name_i;
        res_d.offset      = query_q - rd_addr_i;
        state_d           = FSM_RESP;
      end
      FSM_RESP: begin
        if (res_take_i) begin
          state_d = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

  // Writes happen only from idle and read data is used only during a search,
  // so no read whose data is used meets a write of the same entry in flight.

  a_probe_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FSM_PROBE |-> (lo_q <= mid_q && mid_q < hi_q && hi_q <= cnt_q))
    else $error("search range out of order");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Depth)
    else $error("entry count beyond table depth");

  a_fetch_after_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FSM_FETCH |-> $past(state_q) == FSM_PROBE)
    else $error("fetch without a finished search");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status != ST_FOUND) |->
      (res_o.entry_index == '0 && res_o.found_name == '0 && res_o.offset == '0))
    else $error("non-found result carries data");

  a_wr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.we |-> (state_q == FSM_IDLE && in_valid_i && cnt_q < Depth))
    else $error("table write outside a load");

endmodule

// ----- design/sorted_table_floor_lookup_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_floor_lookup_top
// Sorted table of (address, name) entries with floor lookup by binary search.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_stall_o | req_type_i, addr_i, name_ref_i
//  out     | output    | out_valid_o / out_stall_i | status_o, entry_index_o,
//          |           |                        | found_name_o, offset_o
//  cfg     | input     | cfg_we_i               | cfg_index_i, cfg_data_i
//
// Clear and load go from idle straight to the response state. A lookup is
// issued from idle, then probes the table one entry per cycle (at most
// ceil(log2(count+1)) probes, 11 for 1024 entries), then fetches the found
// entry and gives the response. The probe loop is bound by the registered
// read of the address memory. A result waits in the output register while
// the next request is taken. Reset clears the entry count, kernel base and
// arena low and sets arena high to all ones; the memories are not cleared.
// ----------------------------------------------------------------------------
module sorted_table_floor_lookup_top #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sftl_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sftl_pkg::DataW-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    req_type_i,
  input  logic [sftl_pkg::DataW-1:0]    addr_i,
  input  logic [sftl_pkg::DataW-1:0]    name_ref_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    status_o,
  output logic [sftl_pkg::IndexW-1:0]   entry_index_o,
  output logic [sftl_pkg::DataW-1:0]    found_name_o,
  output logic [sftl_pkg::DataW-1:0]    offset_o
);
  import sftl_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);

  cfg_t             cfg_q, cfg_d;
  tbl_wr_t          wr;
  logic [IdxW-1:0]  wr_idx, rd_idx;
  logic [DataW-1:0] rd_addr, rd_name;
  logic             res_valid, res_take;
  res_t             res;
  logic             out_valid_q, out_valid_d;
  res_t             out_q, out_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_KERNEL_BASE: cfg_d.kernel_base = cfg_data_i;
        REG_ARENA_LOW:   cfg_d.arena_low   = cfg_data_i;
        REG_ARENA_HIGH:  cfg_d.arena_high  = cfg_data_i;
        default: begin
          // no register here: drop the write
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kernel_base <= '0;
      cfg_q.arena_low   <= '0;
      cfg_q.arena_high  <= '1;
      out_valid_q       <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  // load the output register when it is empty or its beat leaves now
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (res_take) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  sftl_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .addr_i     (addr_i),
    .name_ref_i (name_ref_i),
    .wr_o       (wr),
    .wr_idx_o   (wr_idx),
    .rd_idx_o   (rd_idx),
    .rd_addr_i  (rd_addr),
    .rd_name_i  (rd_name),
    .res_valid_o(res_valid),
    .res_take_i (res_take),
    .res_o      (res)
  );

  sftl_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i    (clk_i),
    .wr_i     (wr),
    .wr_idx_i (wr_idx),
    .rd_idx_i (rd_idx),
    .rd_addr_o(rd_addr),
    .rd_name_o(rd_name)
  );

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign entry_index_o = out_q.entry_index;
  assign found_name_o  = out_q.found_name;
  assign offset_o      = out_q.offset;

endmodule

// ----- tb/sorted_table_floor_lookup_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_floor_lookup_top_tb
// Drives clear, load and lookup requests into the sorted table block, keeps a
// shadow of the table and the arena and kernel-base registers, and checks each
// result beat field by field against the shadow's floor search.
// ----------------------------------------------------------------------------
module sorted_table_floor_lookup_top_tb;
  import sftl_pkg::*;

  localparam int TableDepth  = 1024;
  localparam int DrainCycles = 30;
  localparam int QuietLimit  = 2000;
  localparam int HoldCycles  = 300;
  localparam int HoldAtBeat  = 500;

  typedef struct packed {
    logic             drain;
    logic [1:0]       req;
    logic [DataW-1:0] addr;
    logic [DataW-1:0] name;
  } table_req_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index_i   = '0;
  logic [DataW-1:0]     cfg_data_i    = '0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           req_type_i    = '0;
  logic [DataW-1:0]     addr_i        = '0;
  logic [DataW-1:0]     name_ref_i    = '0;
  logic                 out_valid_o;
  logic                 out_stall_i   = 1'b0;
  logic [2:0]           status_o;
  logic [IndexW-1:0]    entry_index_o;
  logic [DataW-1:0]     found_name_o;
  logic [DataW-1:0]     offset_o;

  sorted_table_floor_lookup_top #(
    .TABLE_DEPTH(TableDepth)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .addr_i        (addr_i),
    .name_ref_i    (name_ref_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .entry_index_o (entry_index_o),
    .found_name_o  (found_name_o),
    .offset_o      (offset_o)
  );

  // shadow table and registers
  logic [DataW-1:0] tbl_addr [TableDepth];
  logic [DataW-1:0] tbl_name [TableDepth];
  int               tbl_count;
  logic [DataW-1:0] cfg_kernel_base = '0;
  logic [DataW-1:0] cfg_arena_low   = '0;
  logic [DataW-1:0] cfg_arena_high  = '1;

  table_req_t       requests_pending [$];
  res_t             lookup_results_due [$];
  logic [DataW-1:0] loaded_addrs [$];
  table_req_t       offer;
  res_t             due_now;

  logic in_beat      = 1'b0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_left     = 0;
  bit   hold_done     = 1'b0;
  int   result_beats  = 0;
  int   mismatches    = 0;
  int   quiet_cycles  = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Shadow of one accepted request: update the table, queue the result beat.
  task automatic table_apply(input logic [1:0] rq, input logic [DataW-1:0] a,
                             input logic [DataW-1:0] nm);
    res_t r;
    int   lo;
    int   hi;
    int   mid;
    r = '0;
    case (rq)
      REQ_CLEAR: begin
        tbl_count = 0;
        r.status = ST_CLEARED;
        lookup_results_due.push_back(r);
      end
      REQ_LOAD: begin
        if (a >= cfg_arena_low && a < cfg_arena_high && tbl_count < TableDepth) begin
          tbl_addr[tbl_count] = a;
          tbl_name[tbl_count] = nm;
          tbl_count++;
          r.status = ST_ACCEPTED;
        end else begin
          r.status = ST_DROPPED;
        end
        lookup_results_due.push_back(r);
      end
      REQ_LOOKUP: begin
        if (a < cfg_kernel_base) begin
          r.status = ST_BELOW_BASE;
        end else begin
          lo = 0;
          hi = tbl_count;
          while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (tbl_addr[mid] <= a) begin
              lo = mid + 1;
            end else begin
              hi = mid;
            end
          end
          if (lo == 0) begin
            r.status = ST_NO_COVER;
          end else begin
            r.status      = ST_FOUND;
            r.entry_index = IndexW'(lo - 1);
            r.found_name  = tbl_name[lo - 1];
            r.offset      = a - tbl_addr[lo - 1];
          end
        end
        lookup_results_due.push_back(r);
      end
      default: ; // unused code: no beat comes back
    endcase
  endtask

  // Sample both channels at the rising edge.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_beat <= 1'b0;
    end else begin
      in_beat <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        table_apply(req_type_i, addr_i, name_ref_i);
      end
      if (out_valid_o && !out_stall_i) begin
        result_beats++;
        if (lookup_results_due.size() == 0) begin
          $error("unexpected result beat: status %0d", status_o);
          mismatches++;
        end else begin
          due_now = lookup_results_due.pop_front();
          if (status_o !== due_now.status) begin
            $error("status: expected %0d, got %0d", due_now.status, status_o);
            mismatches++;
          end
          if (entry_index_o !== due_now.entry_index) begin
            $error("entry_index: expected %0d, got %0d", due_now.entry_index,
                   entry_index_o);
            mismatches++;
          end
          if (found_name_o !== due_now.found_name) begin
            $error("found_name: expected %h, got %h", due_now.found_name, found_name_o);
            mismatches++;
          end
          if (offset_o !== due_now.offset) begin
            $error("offset: expected %h, got %h", due_now.offset, offset_o);
            mismatches++;
          end
        end
      end
    end
  end

  // Request driver: advance after a beat, hold while stalled.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_beat) begin
      if (requests_pending.size() != 0 && $urandom_range(99) >= send_idle_pct &&
          !(requests_pending[0].drain && lookup_results_due.size() != 0)) begin
        offer = requests_pending.pop_front();
        req_type_i <= offer.req;
        addr_i     <= offer.addr;
        name_ref_i <= offer.name;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver, with one long hold-off once traffic is flowing.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (!hold_done && result_beats >= HoldAtBeat) begin
      hold_done   <= 1'b1;
      hold_left   <= HoldCycles;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("sorted_table_floor_lookup_top: mismatch");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_req(input logic [1:0] rq, input logic [DataW-1:0] a,
                          input logic [DataW-1:0] nm, input logic dr);
    table_req_t t;
    t.drain = dr;
    t.req   = rq;
    t.addr  = a;
    t.name  = nm;
    requests_pending.push_back(t);
  endtask

  // Query near something loaded: exact hit, just above, just below, or anywhere.
  function automatic logic [DataW-1:0] aim_addr();
    logic [DataW-1:0] hit;
    if (loaded_addrs.size() == 0) begin
      return $urandom;
    end
    hit = loaded_addrs[$urandom_range(loaded_addrs.size() - 1)];
    case ($urandom_range(5))
      0, 1:    return hit;
      2:       return hit + $urandom_range(15);
      3:       return hit - 1;
      4:       return hit + $urandom_range(32'h003F_FFFF);
      default: return $urandom;
    endcase
  endfunction

  // Mostly ascending loads with lookups between them, plus noise.
  task automatic queue_session(input int n, input logic [DataW-1:0] start,
                               input int step_max);
    logic [DataW-1:0] cur;
    int               pick;
    cur = start;
    loaded_addrs.delete();
    push_req(REQ_CLEAR, $urandom, $urandom, 1'b0);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        cur = cur + $urandom_range(step_max);
        push_req(REQ_LOAD, cur, $urandom, 1'b0);
        loaded_addrs.push_back(cur);
      end else if (pick < 85) begin
        push_req(REQ_LOOKUP, aim_addr(), $urandom, $urandom_range(49) == 0);
      end else if (pick < 88) begin
        push_req(REQ_CLEAR, $urandom, $urandom, 1'b0);
        loaded_addrs.delete();
        cur = start;
      end else begin
        push_req(2'($urandom_range(3)), $urandom, $urandom, 1'b0);
      end
    end
  endtask

  // Wait until every queued request is out and every beat is back.
  task automatic settle();
    while (requests_pending.size() != 0 || in_valid_i || lookup_results_due.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_e idx, input logic [DataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      REG_KERNEL_BASE: cfg_kernel_base = val;
      REG_ARENA_LOW:   cfg_arena_low   = val;
      REG_ARENA_HIGH:  cfg_arena_high  = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic start_phase(input logic [DataW-1:0] kb, input logic [DataW-1:0] lo,
                             input logic [DataW-1:0] hi, input int send_pct,
                             input int recv_pct);
    settle();
    write_reg(REG_KERNEL_BASE, kb);
    write_reg(REG_ARENA_LOW, lo);
    write_reg(REG_ARENA_HIGH, hi);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  initial begin
    logic [DataW-1:0] cur;
    tbl_count = 0;
    send_idle_pct = 26;
    recv_idle_pct = 48;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset register values, empty table, equal and unsorted loads
    push_req(REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b0);
    push_req(2'd3,       32'h0000_0000, 32'h0000_0000, 1'b0);
    push_req(REQ_LOAD,   32'hFFFF_FFFF, 32'h1234_5678, 1'b0);
    push_req(REQ_LOAD,   32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    push_req(REQ_LOAD,   32'h0000_0100, 32'h0000_0000, 1'b0);
    push_req(REQ_LOAD,   32'h0000_0100, 32'hA5A5_A5A5, 1'b0);
    push_req(REQ_LOAD,   32'h0000_0050, 32'h0F0F_0F0F, 1'b0);
    push_req(REQ_LOAD,   32'hFFFF_FFFE, 32'h5A5A_5A5A, 1'b0);
    push_req(REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b0);
    push_req(REQ_LOOKUP, 32'h0000_0100, 32'h0000_0000, 1'b0);
    push_req(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    push_req(REQ_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
    push_req(REQ_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    push_req(REQ_LOOKUP, 32'h0000_0005, 32'h0000_0000, 1'b0);
    push_req(REQ_LOAD,   32'h0000_0200, 32'h8000_0001, 1'b0);
    push_req(REQ_LOOKUP, 32'h0000_01FF, 32'h0000_0000, 1'b0);
    push_req(REQ_LOOKUP, 32'h0000_0200, 32'h0000_0000, 1'b1);
    push_req(2'd3,       32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    push_req(REQ_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);

    // kernel base and arena edges
    start_phase(32'h0000_1000, 32'h0000_0800, 32'hF000_0000, 26, 48);
    push_req(REQ_LOOKUP, 32'h0000_0FFF, 32'h0000_0000, 1'b0);
    push_req(REQ_LOOKUP, 32'h0000_1000, 32'h0000_0000, 1'b0);
    push_req(REQ_LOAD,   32'h0000_07FF, 32'h0000_0001, 1'b0);
    push_req(REQ_LOAD,   32'h0000_0800, 32'h0000_0002, 1'b0);
    push_req(REQ_LOAD,   32'hEFFF_FFFF, 32'h0000_0003, 1'b0);
    push_req(REQ_LOAD,   32'hF000_0000, 32'h0000_0004, 1'b0);
    queue_session(200, 32'h0000_0700, 32'h0010_0000);

    // fill the table past its depth, with lookups along the way
    start_phase(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 48, 26);
    cur = $urandom_range(255);
    loaded_addrs.delete();
    push_req(REQ_CLEAR, $urandom, $urandom, 1'b0);
    for (int i = 0; i < TableDepth + 6; i++) begin
      cur = cur + $urandom_range(32'h0030_0000);
      push_req(REQ_LOAD, cur, $urandom, 1'b0);
      loaded_addrs.push_back(cur);
      if ($urandom_range(5) == 0) begin
        push_req(REQ_LOOKUP, aim_addr(), $urandom, $urandom_range(49) == 0);
      end
    end
    repeat (40) push_req(REQ_LOOKUP, aim_addr(), $urandom, 1'b0);

    // empty arena, highest kernel base
    start_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 0, 0);
    queue_session(80, 32'h7FFF_FF00, 64);

    start_phase(32'h8000_0000, 32'h7000_0000, 32'hC000_0000, 0, 0);
    queue_session(150, 32'h6FFF_F000, 32'h0100_0000);

    settle();
    if (mismatches == 0) begin
      $display("sorted_table_floor_lookup_top: match");
    end else begin
      $display("sorted_table_floor_lookup_top: mismatch");
    end
    $finish;
  end

endmodule
